// ===== hdl/rfc_pkg.sv =====
// Package for the reciprocal frequency counter.
// Holds field widths, reset values, register indexes and the types that
// pass between the controller and the datapath. No dependencies.
`default_nettype none

package rfc_pkg;

  localparam int COUNT_WIDTH_DEF = 24;
  localparam int RATE_WIDTH      = 27;
  localparam int LIMIT_WIDTH     = 16;
  localparam int PERIOD_WIDTH    = 24;
  localparam int FREQ_WIDTH      = 27;
  localparam int OVF_SHIFT       = 8;
  localparam int IN_DATA_WIDTH   = 8;
  localparam int OUT_DATA_WIDTH  = 56;
  localparam int CFG_DATA_WIDTH  = 27;

  localparam logic [RATE_WIDTH-1:0]   RATE_RESET  = 27'd16000000;
  localparam logic [LIMIT_WIDTH-1:0]  LIMIT_RESET = 16'hFFFF;
  localparam logic [PERIOD_WIDTH-1:0] PERIOD_MAX  = 24'hFFFFFF;

  typedef enum logic [0:0] {
    REG_TICK_RATE = 1'b0,
    REG_TIMEOUT   = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_WAIT  = 2'd1,
    PH_COUNT = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_STEP = 2'd1,
    ST_DIV  = 2'd2
  } ctrl_state_t;

  typedef struct packed {
    logic step;
    logic div_start;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic stale;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/rfc_div.sv =====
// Restoring divider, one quotient bit per cycle, for the frequency result.
// Depends on rfc_pkg for the dividend width.
`default_nettype none

module rfc_div
  import rfc_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [RATE_WIDTH-1:0]  dividend,
  input  wire logic [COUNT_WIDTH-1:0] divisor,
  output logic                        done,
  output logic [RATE_WIDTH-1:0]       quotient
);

  localparam int STEP_W = $clog2(RATE_WIDTH);

  logic                   busy;
  logic [STEP_W-1:0]      steps;
  logic [COUNT_WIDTH-1:0] rem;
  logic [COUNT_WIDTH-1:0] dvs;
  logic [RATE_WIDTH-1:0]  quo;
  logic [COUNT_WIDTH:0]   rem_sh;
  logic [COUNT_WIDTH:0]   diff;
  logic                   fits;

  assign rem_sh = {rem, quo[RATE_WIDTH-1]};
  assign diff   = rem_sh - {1'b0, dvs};
  assign fits   = !diff[COUNT_WIDTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (steps == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (steps == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      steps <= STEP_W'(RATE_WIDTH - 1);
      rem   <= '0;
      dvs   <= divisor;
      quo   <= dividend;
    end else if (busy) begin
      steps <= steps - 1'b1;
      rem   <= fits ? diff[COUNT_WIDTH-1:0] : rem_sh[COUNT_WIDTH-1:0];
      quo   <= {quo[RATE_WIDTH-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

// ===== hdl/rfc_datapath.sv =====
// Datapath: configuration registers, measurement state, tick counter,
// cached frequency and the output register. Depends on rfc_pkg and rfc_div.
`default_nettype none

module rfc_datapath
  import rfc_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_wen,
  input  wire logic                      cfg_index,
  input  wire logic [CFG_DATA_WIDTH-1:0] cfg_wdata,
  input  wire logic [IN_DATA_WIDTH-1:0]  in_data,
  input  wire ctrl_cmd_t                 cmd,
  output dp_status_t                     status,
  output logic [OUT_DATA_WIDTH-1:0]      out_data
);

  localparam int LW = (COUNT_WIDTH > PERIOD_WIDTH) ? COUNT_WIDTH : PERIOD_WIDTH;

  logic [RATE_WIDTH-1:0]  tick_rate;
  logic [LIMIT_WIDTH-1:0] timeout_ovf;
  phase_t                 phase;
  phase_t                 phase_next;
  logic [COUNT_WIDTH-1:0] tick_count;
  logic [COUNT_WIDTH-1:0] tick_count_next;
  logic [COUNT_WIDTH-1:0] last_period;
  logic [COUNT_WIDTH-1:0] last_period_next;
  logic                   done_flag;
  logic                   done_flag_next;
  logic                   timeout_flag;
  logic                   timeout_flag_next;
  logic                   period_set;
  logic                   stale;
  logic [FREQ_WIDTH-1:0]  freq;

  logic                   start_req;
  logic                   abort_req;
  logic                   edge_seen;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic [COUNT_WIDTH-1:0] cnt_mask;
  logic [LW-1:0]          lim_raw;
  logic [LW-1:0]          lim;
  logic [LW-1:0]          period_ext;
  logic [PERIOD_WIDTH-1:0] period_out;
  logic                   per_zero;
  logic                   div_done;
  logic [RATE_WIDTH-1:0]  quotient;

  assign start_req = in_data[0];
  assign abort_req = in_data[1];
  assign edge_seen = in_data[2];

  assign count_inc = tick_count + 1'b1;
  assign cnt_mask  = '1;
  assign lim_raw   = LW'({timeout_ovf, OVF_SHIFT'(0)});
  assign lim       = (lim_raw > LW'(cnt_mask)) ? LW'(cnt_mask) : lim_raw;

  always_comb begin
    phase_next        = phase;
    tick_count_next   = tick_count;
    last_period_next  = last_period;
    done_flag_next    = done_flag;
    timeout_flag_next = timeout_flag;
    period_set        = 1'b0;
    if (abort_req) begin
      phase_next     = PH_IDLE;
      done_flag_next = 1'b1;
    end else begin
      unique case (phase)
        PH_IDLE: begin
          if (start_req) begin
            tick_count_next   = '0;
            done_flag_next    = 1'b0;
            timeout_flag_next = 1'b0;
            phase_next        = PH_WAIT;
          end
        end
        PH_WAIT: begin
          if (edge_seen) begin
            tick_count_next = '0;
            phase_next      = PH_COUNT;
          end
        end
        PH_COUNT: begin
          tick_count_next = count_inc;
          if (edge_seen) begin
            last_period_next = count_inc;
            done_flag_next   = 1'b1;
            phase_next       = PH_IDLE;
            period_set       = 1'b1;
          end else if (LW'(count_inc) >= lim) begin
            last_period_next  = '0;
            tick_count_next   = '0;
            timeout_flag_next = 1'b1;
            done_flag_next    = 1'b1;
            phase_next        = PH_IDLE;
            period_set        = 1'b1;
          end
        end
        default: begin
          phase_next     = PH_IDLE;
          done_flag_next = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_rate    <= RATE_RESET;
      timeout_ovf  <= LIMIT_RESET;
      phase        <= PH_IDLE;
      tick_count   <= '0;
      last_period  <= '0;
      done_flag    <= 1'b1;
      timeout_flag <= 1'b0;
    end else begin
      if (cfg_wen) begin
        unique case (reg_index_t'(cfg_index))
          REG_TICK_RATE: tick_rate   <= cfg_wdata[RATE_WIDTH-1:0];
          REG_TIMEOUT:   timeout_ovf <= cfg_wdata[LIMIT_WIDTH-1:0];
          default: ;
        endcase
      end
      if (cmd.step) begin
        phase        <= phase_next;
        tick_count   <= tick_count_next;
        last_period  <= last_period_next;
        done_flag    <= done_flag_next;
        timeout_flag <= timeout_flag_next;
      end
    end
  end

  // The frequency is cached and refreshed only after a new period is set or the tick rate is written.
  assign per_zero = (last_period == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      stale <= 1'b0;
      freq  <= '0;
    end else begin
      if (cmd.div_start && per_zero) begin
        freq  <= '0;
        stale <= 1'b0;
      end else if (div_done) begin
        freq  <= quotient;
        stale <= 1'b0;
      end else if ((cmd.step && period_set) ||
                   (cfg_wen && (reg_index_t'(cfg_index) == REG_TICK_RATE))) begin
        stale <= 1'b1;
      end
    end
  end

  rfc_div #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start && !per_zero),
    .dividend (tick_rate),
    .divisor  (last_period),
    .done     (div_done),
    .quotient (quotient)
  );

  assign status.stale = stale;

  assign period_ext = LW'(last_period);
  assign period_out = (period_ext > LW'(PERIOD_MAX)) ? PERIOD_MAX
                                                     : period_ext[PERIOD_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= {1'b0, freq, period_out, timeout_flag, done_flag, phase};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rfc_ctrl.sv =====
// Controller state machine: sequences one tick item through the state
// update, an optional division and the output transfer. Depends on rfc_pkg.
`default_nettype none

module rfc_ctrl
  import rfc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    in_ready       = 1'b0;
    cmd            = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = !out_valid || out_ready;
        if (in_valid && in_ready) begin
          cmd.step   = 1'b1;
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        if (status.stale) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end else begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (!status.stale) begin
          state_next = ST_STEP;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/reciprocal_frequency_counter.sv =====
// Top level of the reciprocal frequency counter.
// Depends on rfc_pkg, rfc_ctrl and rfc_datapath.
//
//  Channel  Direction  Content
//  s_axis   in         one timer tick: start, abort and edge flags
//  m_axis   out        state after the tick, period and frequency
//  cfg      in         writes of tick_rate_hz and timeout_overflows
//
// The result of an item is loaded straight after the state update when no
// period was set and the tick rate was not written since the previous result;
// otherwise the frequency is first refreshed: set to zero for a period of zero,
// and else recomputed by the 27-step restoring divider.
// Reset is synchronous; the result register holds while m_axis_tready is
// low, and no new item is taken until that result is transferred.
`default_nettype none

module reciprocal_frequency_counter
  import rfc_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  // start_request, abort_request, signal_edge, then zero fill
  input  wire logic [IN_DATA_WIDTH-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  // phase[1:0], done_res, timed_out, period_ticks[23:0], freq_hz[26:0], zero
  output logic [OUT_DATA_WIDTH-1:0]      m_axis_tdata,
  input  wire logic                      cfg_wen,
  input  wire logic                      cfg_index,
  input  wire logic [CFG_DATA_WIDTH-1:0] cfg_wdata
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  rfc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  rfc_datapath #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (s_axis_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_data  (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ===== hdl/rfc_checker.sv =====
// Port-level checks for the reciprocal frequency counter, bound to the top.
// Depends on rfc_pkg and reciprocal_frequency_counter.
`default_nettype none

module rfc_checker
  import rfc_pkg::*;
(
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      s_axis_tvalid,
  input wire logic                      s_axis_tready,
  input wire logic                      m_axis_tvalid,
  input wire logic                      m_axis_tready,
  input wire logic [OUT_DATA_WIDTH-1:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed or dropped while stalled");

  a_no_take_when_full: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("item taken while a result is still waiting");

  a_result_not_early: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
    else $error("result shown in the cycle after a transfer in");

  a_done_means_idle: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[2] == (m_axis_tdata[1:0] == PH_IDLE)))
    else $error("done flag disagrees with phase");

  a_timeout_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[3] |->
      (m_axis_tdata[27:4] == '0) && (m_axis_tdata[54:28] == '0))
    else $error("timed out result with nonzero period or frequency");

endmodule

bind reciprocal_frequency_counter rfc_checker u_rfc_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
